@@ src/bsmw_pkg.sv @@
// ----------------------------------------------------------------------------
// bsmw_pkg
// types and constants of the bank-switched memory window core
// ----------------------------------------------------------------------------
package bsmw_pkg;

   // request kinds carried on the request tuser
   typedef enum logic [2:0] {
      OP_MEM_READ   = 3'd0,
      OP_MEM_WRITE  = 3'd1,
      OP_PORT_READ  = 3'd2,
      OP_PORT_WRITE = 3'd3,
      OP_HOST_LOAD  = 3'd4,
      OP_DEV_RESET  = 3'd5
   } op_type;

   // control register indexes
   typedef enum logic [2:0] {
      CSR_WINDOW_BASE   = 3'd0,
      CSR_PAGE_COUNT    = 3'd1,
      CSR_BANK_COUNT    = 3'd2,
      CSR_SINGLE_IMAGE  = 3'd3,
      CSR_IMAGE_SIZE    = 3'd4,
      CSR_BANK_LENGTHS  = 3'd5,
      CSR_WRITABLE_MASK = 3'd6
   } csr_idx_type;

   // field widths
   localparam int unsigned OP_W      = 3;
   localparam int unsigned CPU_W     = 16;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned SADDR_W   = 18;
   localparam int unsigned IMG_W     = 19;
   localparam int unsigned LENS_W    = 64;
   localparam int unsigned LEN_W     = 16;
   localparam int unsigned MASK_W    = 4;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned REQ_W     = 48;

   // width of bank start and image arithmetic: covers 255 * 65280 plus an offset
   localparam int unsigned SUM_W = 25;

   // reciprocal for the region index, exact for 8-bit bank numbers
   localparam int unsigned RECIP_SHIFT = 16;

endpackage

@@ src/bank_switched_memory_window_core.sv @@
// ----------------------------------------------------------------------------
// bank_switched_memory_window_core
// banked window of a byte-wide backing store with bank-select port
// ----------------------------------------------------------------------------
// path: the store read and the read stage are registered at the accept edge,
//   then the output register drives rsp_tvalid
// throughput: one request word per cycle while the response side is ready;
//   the single store port takes one read or one write per request
// reset: synchronous, clears config to defaults, selects bank zero with zero
//   length; the backing store holds no reset value and needs no clearing pass
module bank_switched_memory_window_core #(
   parameter int unsigned NUM_REGIONS = 4,      // 1 to 4 regions in multi-region mode
   parameter int unsigned STORE_BYTES = 262144  // power of two, 65536 to 1048576
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // cpu_address[15:0], write_data[23:16], store_address[41:24]
   input  logic [2:0]  req_tuser,   // opcode[2:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // read_data[7:0]
   output logic [0:0]  rsp_tuser,   // window_hit[0]
   // control register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int unsigned ADDR_W = $clog2(STORE_BYTES);
   localparam int unsigned SUM_W  = bsmw_pkg::SUM_W;
   localparam int unsigned RECIP  =
      ((1 << bsmw_pkg::RECIP_SHIFT) + NUM_REGIONS - 1) / NUM_REGIONS;
   localparam logic [SUM_W-1:0] REGION_SZ  = SUM_W'(STORE_BYTES / NUM_REGIONS);
   localparam logic [SUM_W-1:0] REGION_SZ2 = SUM_W'(2 * (STORE_BYTES / NUM_REGIONS));
   localparam logic [SUM_W-1:0] REGION_SZ3 = SUM_W'(3 * (STORE_BYTES / NUM_REGIONS));
   localparam logic [SUM_W-1:0] STORE_SZ   = SUM_W'(STORE_BYTES);

   // ---------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------
   logic [15:0] window_base_ff;
   logic [7:0]  page_count_ff;
   logic [7:0]  bank_count_ff;
   logic        single_image_ff;
   logic [18:0] image_size_ff;
   logic [63:0] bank_lengths_ff;
   logic [3:0]  writable_mask_ff;

   // always ready; the user must write only while the core is idle, not enforced here
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_base_ff   <= '0;
         page_count_ff    <= 8'd1;
         bank_count_ff    <= 8'd1;
         single_image_ff  <= 1'b0;
         image_size_ff    <= '0;
         bank_lengths_ff  <= '0;
         writable_mask_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (bsmw_pkg::csr_idx_type'(csr_index))
            bsmw_pkg::CSR_WINDOW_BASE:   window_base_ff   <= csr_data[15:0];
            bsmw_pkg::CSR_PAGE_COUNT:    page_count_ff    <= csr_data[7:0];
            bsmw_pkg::CSR_BANK_COUNT:    bank_count_ff    <= csr_data[7:0];
            bsmw_pkg::CSR_SINGLE_IMAGE:  single_image_ff  <= csr_data[0];
            bsmw_pkg::CSR_IMAGE_SIZE:    image_size_ff    <= csr_data[18:0];
            bsmw_pkg::CSR_BANK_LENGTHS:  bank_lengths_ff  <= csr_data;
            bsmw_pkg::CSR_WRITABLE_MASK: writable_mask_ff <= csr_data[3:0];
            default: ;  // unknown index, dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // bank state, latched at select time
   // ---------------------------------------------------------------------
   logic [7:0]  selected_bank_ff, selected_bank_in;
   logic [15:0] current_length_ff, current_length_in;
   logic        current_writable_ff, current_writable_in;
   logic [1:0]  region_ff, region_in;  // selected bank mod region count

   // ---------------------------------------------------------------------
   // request fields
   // ---------------------------------------------------------------------
   bsmw_pkg::op_type op;
   logic [15:0] cpu_address;
   logic [7:0]  write_data;
   logic [17:0] store_address;
   logic        req_accept;

   assign op            = bsmw_pkg::op_type'(req_tuser);
   assign cpu_address   = req_tdata[15:0];
   assign write_data    = req_tdata[23:16];
   assign store_address = req_tdata[41:24];
   assign req_accept    = req_tvalid && req_tready;

   // ---------------------------------------------------------------------
   // window decode for memory accesses
   // ---------------------------------------------------------------------
   logic [15:0]      win_bytes;
   logic [15:0]      offset;
   logic             in_window;
   logic             in_length;
   logic [15:0]      sel_pages;      // selected bank times page count
   logic [SUM_W-1:0] bank_start;
   logic [SUM_W-1:0] store_pos;

   assign win_bytes = {page_count_ff, 8'h00};
   assign offset    = cpu_address - window_base_ff;   // wraps mod 64k
   assign in_window = offset < win_bytes;
   assign in_length = offset < current_length_ff;
   assign sel_pages = 16'(selected_bank_ff * page_count_ff);

   always_comb begin
      if (single_image_ff) begin
         bank_start = SUM_W'({sel_pages, 8'h00});
      end else begin
         case (region_ff)
            2'd0:    bank_start = '0;
            2'd1:    bank_start = REGION_SZ;
            2'd2:    bank_start = REGION_SZ2;
            default: bank_start = REGION_SZ3;
         endcase
      end
   end

   // store size is a power of two, so the wrap is a truncation
   assign store_pos = bank_start + SUM_W'(offset);

   // ---------------------------------------------------------------------
   // bank select: new length and write permission
   // ---------------------------------------------------------------------
   logic [7:0]       sel_bank;
   logic             sel_req;
   logic             sel_ok;
   logic [15:0]      new_pages;
   logic [SUM_W-1:0] new_start;
   logic [SUM_W-1:0] image_cap;
   logic [SUM_W-1:0] image_rest;
   logic [SUM_W-1:0] packed_len;
   logic [SUM_W-1:0] len_single;
   logic [SUM_W-1:0] len_multi;
   logic [SUM_W-1:0] size_wide;
   logic [1:0]       sel_lane;
   logic [24:0]      recip_prod;
   logic [7:0]       quot;
   logic [7:0]       rem_full;

   assign sel_bank  = (op == bsmw_pkg::OP_PORT_WRITE) ? write_data : 8'd0;
   assign sel_lane  = sel_bank[1:0];
   assign size_wide = SUM_W'(win_bytes);
   assign new_pages = 16'(sel_bank * page_count_ff);
   assign new_start = SUM_W'({new_pages, 8'h00});
   assign image_cap = (SUM_W'(image_size_ff) > STORE_SZ) ? STORE_SZ : SUM_W'(image_size_ff);
   assign image_rest = (new_start >= image_cap) ? '0 : image_cap - new_start;
   assign len_single = (image_rest > size_wide) ? size_wide : image_rest;
   assign packed_len = SUM_W'(bank_lengths_ff[16*sel_lane +: 16]);

   always_comb begin
      len_multi = packed_len;
      if (len_multi > size_wide) begin
         len_multi = size_wide;
      end
      if (len_multi > REGION_SZ) begin
         len_multi = REGION_SZ;
      end
   end

   // bank number mod region count by multiply with the reciprocal
   assign recip_prod = 25'(sel_bank * 17'(RECIP));
   assign quot       = recip_prod[bsmw_pkg::RECIP_SHIFT +: 8];
   assign rem_full   = sel_bank - 8'(quot * 8'(NUM_REGIONS));

   // port write to a different bank, or device reset
   assign sel_req = ((op == bsmw_pkg::OP_PORT_WRITE) && (write_data != selected_bank_ff))
                 || (op == bsmw_pkg::OP_DEV_RESET);
   assign sel_ok  = (sel_bank < bank_count_ff)
                 && (single_image_ff || (sel_bank < 8'(NUM_REGIONS)));

   always_comb begin
      selected_bank_in    = selected_bank_ff;
      current_length_in   = current_length_ff;
      current_writable_in = current_writable_ff;
      region_in           = region_ff;
      if (req_accept && sel_req && sel_ok) begin
         selected_bank_in = sel_bank;
         region_in        = rem_full[1:0];
         if (single_image_ff) begin
            current_length_in   = len_single[15:0];
            current_writable_in = writable_mask_ff[0];
         end else begin
            current_length_in   = len_multi[15:0];
            current_writable_in = writable_mask_ff[sel_lane];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         selected_bank_ff    <= '0;
         current_length_ff   <= '0;
         current_writable_ff <= 1'b0;
         region_ff           <= '0;
      end else begin
         selected_bank_ff    <= selected_bank_in;
         current_length_ff   <= current_length_in;
         current_writable_ff <= current_writable_in;
         region_ff           <= region_in;
      end
   end

   // ---------------------------------------------------------------------
   // backing store: one port, read data registered
   // ---------------------------------------------------------------------
   logic [7:0]        store_mem [STORE_BYTES];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] mem_addr;
   logic              mem_we;
   logic              mem_re;

   // decode of the accepted word into store access and immediate result
   logic       use_mem;    // result comes from the store read
   logic       hit;
   logic [7:0] imm_data;

   always_comb begin
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      mem_addr = ADDR_W'(store_pos);
      use_mem  = 1'b0;
      hit      = 1'b0;
      imm_data = 8'h00;
      unique case (op)
         bsmw_pkg::OP_MEM_READ: begin
            hit     = in_window;
            use_mem = in_window && in_length;
            mem_re  = req_accept && use_mem;
         end
         bsmw_pkg::OP_MEM_WRITE: begin
            hit    = in_window;
            mem_we = req_accept && in_window && in_length && current_writable_ff;
         end
         bsmw_pkg::OP_PORT_READ: begin
            imm_data = selected_bank_ff;
         end
         bsmw_pkg::OP_HOST_LOAD: begin
            mem_addr = ADDR_W'(store_address);
            mem_we   = req_accept;
         end
         default: ;  // port write, device reset, unused codes: result zero
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= write_data;
      end else if (mem_re) begin
         rd_data_ff <= store_mem[mem_addr];
      end
   end

   // ---------------------------------------------------------------------
   // result pipeline: read stage, then output register
   // ---------------------------------------------------------------------
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_use_mem_ff;
   logic       s1_hit_ff;
   logic [7:0] s1_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff;
   logic       rsp_hit_ff;
   logic       out_free;
   logic       s1_adv;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   // a held read word in the read stage blocks new requests
   assign req_tready = !s1_valid_ff || out_free;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_use_mem_ff <= use_mem;
         s1_hit_ff     <= hit;
         s1_data_ff    <= imm_data;
      end
      if (s1_adv) begin
         rsp_data_ff <= s1_use_mem_ff ? rd_data_ff : s1_data_ff;
         rsp_hit_ff  <= s1_hit_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_hit_ff;

`ifndef SYNTHESIS
   // region index always names an existing region
   a_region_range: assert property (@(posedge clock) disable iff (reset)
      32'(region_ff) < NUM_REGIONS)
      else $error("region index out of range");

   // a store read is only ever pending for a window hit
   a_mem_implies_hit: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_use_mem_ff |-> s1_hit_ff)
      else $error("store read without window hit");

   // an accepted word always lands in the read stage
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted word lost");

   // the read stage must not be overwritten while it is held
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |-> !req_tready)
      else $error("read stage overrun");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the bank-switched memory window core: a scoreboard
// class mirrors the config, the bank select and the backing store, predicts
// one response word per request word and compares it field by field
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned NUM_REGIONS  = 4;
   localparam int unsigned STORE_BYTES  = 262144;
   localparam int unsigned REGION_BYTES = STORE_BYTES / NUM_REGIONS;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned IDLE_PCT     = 22;
   localparam int unsigned PHASE_WORDS  = 90;

   // one expected response word
   typedef struct packed {
      logic [7:0] read_data;
      logic       window_hit;
   } reply_type;

   // one full set of control registers
   typedef struct {
      logic [15:0] base;
      logic [7:0]  pages;
      logic [7:0]  banks;
      logic        single;
      logic [18:0] img;
      logic [63:0] lens;
      logic [3:0]  wmask;
   } window_setting_type;

   // -------------------------------------------------------------------------
   // scoreboard: shadow copy of the window and the store
   // -------------------------------------------------------------------------
   class bank_window_scoreboard;
      logic [15:0] base;
      logic [7:0]  pages;
      logic [7:0]  banks;
      logic        single;
      logic [18:0] img_size;
      logic [63:0] lens;
      logic [3:0]  wmask;
      logic [7:0]  sel;
      int unsigned cur_len;
      logic        cur_wr;
      logic [7:0]  store [STORE_BYTES];
      bit          loaded [STORE_BYTES];
      reply_type   expected_replies [$];
      int unsigned mismatch_count;

      function new();
         base = '0;
         pages = 8'd1;
         banks = 8'd1;
         single = 1'b0;
         img_size = '0;
         lens = '0;
         wmask = '0;
         sel = '0;
         cur_len = 0;
         cur_wr = 1'b0;
         mismatch_count = 0;
         select_bank(0);
      endfunction

      // length and writability are latched here only
      function void select_bank(input int unsigned b);
         int unsigned size;
         int unsigned len;
         int unsigned img;
         int unsigned start;
         size = pages * 32'd256;
         if (b >= banks) return;
         if (single) begin
            img = 32'(img_size);
            if (img > STORE_BYTES) img = STORE_BYTES;
            start = b * size;
            len = (start >= img) ? 0 : img - start;
            if (len > size) len = size;
            cur_wr = wmask[0];
         end else begin
            if (b >= NUM_REGIONS) return;
            len = 32'(lens[16*b +: 16]);
            if (len > size) len = size;
            if (len > REGION_BYTES) len = REGION_BYTES;
            cur_wr = wmask[b];
         end
         sel = 8'(b);
         cur_len = len;
      endfunction

      function bit in_window(input logic [15:0] addr);
         logic [15:0] off;
         off = addr - base;
         return off < pages * 32'd256;
      endfunction

      // 1 when a memory access at addr touches the store, pos is the byte
      function bit store_target(input logic [15:0] addr, output int unsigned pos);
         logic [15:0] off;
         int unsigned start;
         off = addr - base;
         start = single ? sel * pages * 32'd256 : (sel % NUM_REGIONS) * REGION_BYTES;
         pos = (start + off) % STORE_BYTES;
         return in_window(addr) && off < cur_len;
      endfunction

      function void write_register(input bsmw_pkg::csr_idx_type idx,
                                   input logic [63:0] value);
         case (idx)
            bsmw_pkg::CSR_WINDOW_BASE:   base = value[15:0];
            bsmw_pkg::CSR_PAGE_COUNT:    pages = value[7:0];
            bsmw_pkg::CSR_BANK_COUNT:    banks = value[7:0];
            bsmw_pkg::CSR_SINGLE_IMAGE:  single = value[0];
            bsmw_pkg::CSR_IMAGE_SIZE:    img_size = value[18:0];
            bsmw_pkg::CSR_BANK_LENGTHS:  lens = value;
            bsmw_pkg::CSR_WRITABLE_MASK: wmask = value[3:0];
            default: ;
         endcase
      endfunction

      function void note_request(input bsmw_pkg::op_type op, input logic [15:0] addr,
                                 input logic [7:0] data, input logic [17:0] saddr);
         reply_type r;
         int unsigned pos;
         bit touches;
         r = '0;
         case (op) inside
            bsmw_pkg::OP_MEM_READ, bsmw_pkg::OP_MEM_WRITE: begin
               touches = store_target(addr, pos);
               r.window_hit = in_window(addr);
               if (touches) begin
                  if (op == bsmw_pkg::OP_MEM_READ) begin
                     r.read_data = store[pos];
                  end else if (cur_wr) begin
                     store[pos] = data;
                     loaded[pos] = 1'b1;
                  end
               end
            end
            bsmw_pkg::OP_PORT_READ:  r.read_data = sel;
            bsmw_pkg::OP_PORT_WRITE: if (data != sel) select_bank(32'(data));
            bsmw_pkg::OP_HOST_LOAD: begin
               store[saddr] = data;
               loaded[saddr] = 1'b1;
            end
            bsmw_pkg::OP_DEV_RESET:  select_bank(0);
            default: ;
         endcase
         expected_replies.push_back(r);
      endfunction

      function void check_reply(input logic [7:0] rd, input logic hit);
         reply_type want;
         if (expected_replies.size() == 0) begin
            $display("%0t: response word with none pending, read_data %02h window_hit %0b",
                     $time, rd, hit);
            mismatch_count++;
            return;
         end
         want = expected_replies.pop_front();
         if (rd !== want.read_data) begin
            $display("%0t: read_data expected %02h actual %02h", $time, want.read_data, rd);
            mismatch_count++;
         end
         if (hit !== want.window_hit) begin
            $display("%0t: window_hit expected %0b actual %0b", $time, want.window_hit, hit);
            mismatch_count++;
         end
      endfunction

      function int unsigned pending();
         return expected_replies.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // dut signals, all inputs known from time zero
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;    // cpu_address[15:0], write_data[23:16], store_address[41:24]
   logic [2:0]  req_tuser = '0;    // opcode[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [7:0]  rsp_tdata;         // read_data[7:0]
   logic [0:0]  rsp_tuser;         // window_hit[0]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   // no idling on either side while set
   bit steady = 1'b0;

   bank_window_scoreboard window_sb = new();

   bank_switched_memory_window_core #(
      .NUM_REGIONS(NUM_REGIONS),
      .STORE_BYTES(STORE_BYTES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit take_gap();
      return !steady && $urandom_range(99) < IDLE_PCT;
   endfunction

   // response side: check every accepted word, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) window_sb.check_reply(rsp_tdata, rsp_tuser[0]);
      rsp_tready <= !take_gap();
   end

   // -------------------------------------------------------------------------
   // request side
   // -------------------------------------------------------------------------
   // valid is only lowered on an idle cycle, so a back-to-back word never
   // sees two assignments in one step
   task automatic send_request(input bsmw_pkg::op_type op, input logic [15:0] addr,
                               input logic [7:0] data, input logic [17:0] saddr);
      while (take_gap()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'd0, saddr, data, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      window_sb.note_request(op, addr, data, saddr);
   endtask

   // a read of a never-loaded byte is preceded by a host load of that byte
   task automatic read_byte(input logic [15:0] addr);
      int unsigned pos;
      if (window_sb.store_target(addr, pos) && !window_sb.loaded[pos])
         send_request(bsmw_pkg::OP_HOST_LOAD, 16'($urandom), 8'($urandom), 18'(pos));
      send_request(bsmw_pkg::OP_MEM_READ, addr, 8'($urandom), 18'($urandom));
   endtask

   // mostly inside the current window, wrapping past 0xffff where it falls
   function automatic logic [15:0] pick_address();
      int unsigned size;
      size = window_sb.pages * 32'd256;
      if (size != 0 && $urandom_range(99) < 85)
         return 16'(window_sb.base + $urandom_range(size - 1));
      return 16'($urandom);
   endfunction

   task automatic random_word();
      logic [15:0] addr;
      int unsigned pos;
      int unsigned pick;
      pick = $urandom_range(99);
      addr = pick_address();
      if (pick < 35) begin
         read_byte(addr);
      end else if (pick < 58) begin
         send_request(bsmw_pkg::OP_MEM_WRITE, addr, 8'($urandom), 18'($urandom));
      end else if (pick < 66) begin
         send_request(bsmw_pkg::OP_PORT_READ, 16'($urandom), 8'($urandom), 18'($urandom));
      end else if (pick < 78) begin
         // mostly legal bank numbers, sometimes anything
         send_request(bsmw_pkg::OP_PORT_WRITE, 16'($urandom),
                      ($urandom_range(3) != 0) ? 8'($urandom_range(window_sb.banks - 1))
                                               : 8'($urandom_range(255)),
                      18'($urandom));
      end else if (pick < 94) begin
         // half the loads land in the bank now shown, so reads find data
         if (window_sb.store_target(addr, pos) && $urandom_range(1))
            send_request(bsmw_pkg::OP_HOST_LOAD, 16'($urandom), 8'($urandom), 18'(pos));
         else
            send_request(bsmw_pkg::OP_HOST_LOAD, 16'($urandom), 8'($urandom),
                         18'($urandom));
      end else begin
         send_request(bsmw_pkg::OP_DEV_RESET, 16'($urandom), 8'($urandom), 18'($urandom));
      end
   endtask

   // -------------------------------------------------------------------------
   // control registers, written only with nothing in flight
   // -------------------------------------------------------------------------
   task automatic write_csr(input bsmw_pkg::csr_idx_type idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      window_sb.write_register(idx, value);
   endtask

   task automatic apply_setting(input window_setting_type s);
      write_csr(bsmw_pkg::CSR_WINDOW_BASE, 64'(s.base));
      write_csr(bsmw_pkg::CSR_PAGE_COUNT, 64'(s.pages));
      write_csr(bsmw_pkg::CSR_BANK_COUNT, 64'(s.banks));
      write_csr(bsmw_pkg::CSR_SINGLE_IMAGE, 64'(s.single));
      write_csr(bsmw_pkg::CSR_IMAGE_SIZE, 64'(s.img));
      write_csr(bsmw_pkg::CSR_BANK_LENGTHS, s.lens);
      write_csr(bsmw_pkg::CSR_WRITABLE_MASK, 64'(s.wmask));
      csr_valid <= 1'b0;
   endtask

   // every request gives a response, so an empty queue means idle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (window_sb.pending() != 0) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      window_setting_type plan [8];
      int phase;

      // multi-region, small banks: bank 0 full and writable, bank 1 short and
      // read-only, bank 2 capped by the bank size, bank 3 empty
      plan[0] = '{16'h1000, 8'd4, 8'd4, 1'b0, 19'd0, 64'h0000_FFFF_0100_0400, 4'b0101};
      // single image, largest banks, window wrapping past the top of memory
      plan[1] = '{16'hFFFF, 8'd255, 8'd255, 1'b1, 19'd262144, '1, 4'hF};
      // zero page count: nothing hits
      plan[2] = '{16'h0000, 8'd0, 8'd1, 1'b0, 19'd0, 64'd0, 4'h0};
      // single image that ends inside bank 3, later banks empty
      plan[3] = '{16'hC000, 8'd1, 8'd255, 1'b1, 19'd1000, 64'd0, 4'b0001};
      // more banks than regions: selects of 4 and up are dropped
      plan[4] = '{16'($urandom), 8'd16, 8'd8, 1'b0, 19'd0, {$urandom, $urandom},
                  4'($urandom)};
      plan[5] = '{16'($urandom), 8'd64, 8'd6, 1'b1, 19'd100000, {$urandom, $urandom}, 4'h0};
      plan[6] = '{16'($urandom), 8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
                  1'($urandom), 19'($urandom_range(262144)), {$urandom, $urandom},
                  4'($urandom)};
      plan[7] = '{16'($urandom), 8'($urandom_range(8, 1)), 8'($urandom_range(6, 1)), 1'b0,
                  19'($urandom_range(262144)), {$urandom, $urandom}, 4'($urandom)};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < 8; phase++) begin
         steady = (phase == 4);
         drain();
         apply_setting(plan[phase]);
         // latch length and writability of bank 0 under the new registers
         send_request(bsmw_pkg::OP_DEV_RESET, 16'($urandom), 8'($urandom), 18'($urandom));

         if (phase == 0) begin
            // bank 0: load, read, overwrite, both ends of the window
            send_request(bsmw_pkg::OP_HOST_LOAD, 16'hFFFF, 8'hA5, 18'h00000);
            read_byte(16'h1000);
            send_request(bsmw_pkg::OP_MEM_WRITE, 16'h1000, 8'h00, 18'h3FFFF);
            read_byte(16'h1000);
            send_request(bsmw_pkg::OP_MEM_WRITE, 16'h13FF, 8'hFF, 18'h00000);
            read_byte(16'h13FF);
            read_byte(16'h1400);
            read_byte(16'h0FFF);
            // bank select: legal, same bank again, out of range
            send_request(bsmw_pkg::OP_PORT_READ, 16'h0000, 8'h00, 18'h00000);
            send_request(bsmw_pkg::OP_PORT_WRITE, 16'h0000, 8'd1, 18'h00000);
            send_request(bsmw_pkg::OP_PORT_WRITE, 16'h0000, 8'd1, 18'h00000);
            send_request(bsmw_pkg::OP_PORT_WRITE, 16'h0000, 8'd4, 18'h00000);
            send_request(bsmw_pkg::OP_PORT_WRITE, 16'h0000, 8'hFF, 18'h00000);
            send_request(bsmw_pkg::OP_PORT_READ, 16'h0000, 8'h00, 18'h00000);
            // read-only bank keeps the loaded byte, past its length reads zero
            send_request(bsmw_pkg::OP_HOST_LOAD, 16'h0000, 8'h5A, 18'h10010);
            send_request(bsmw_pkg::OP_MEM_WRITE, 16'h1010, 8'h77, 18'h00000);
            read_byte(16'h1010);
            read_byte(16'h1100);
            // empty bank hits but returns zero
            send_request(bsmw_pkg::OP_PORT_WRITE, 16'h0000, 8'd3, 18'h00000);
            read_byte(16'h1000);
            send_request(bsmw_pkg::OP_DEV_RESET, 16'h0000, 8'h00, 18'h00000);
            send_request(bsmw_pkg::OP_PORT_READ, 16'h0000, 8'h00, 18'h00000);
         end

         repeat (PHASE_WORDS) random_word();
      end

      drain();
      repeat (8) @(posedge clock);
      if (window_sb.mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // hard stop if the block hangs
   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ bank_switched_memory_window_core.f @@
src/bsmw_pkg.sv
src/bank_switched_memory_window_core.sv
tb/tb.sv
